// File: src/sle_pkg.sv
// shared types, widths and codes of the sorted list engine
package sle_pkg;

   localparam int SLE_CAPACITY = 16;

   localparam int OP_W  = 2;
   localparam int VAL_W = 32;
   localparam int POS_W = 5;
   localparam int ST_W  = 2;
   localparam int LEN_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_BAD_POS = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch request, init walk index
      logic mem_read;    // read list word at op dependent address
      logic mem_write;   // write list word at walk index
      logic wr_value;    // write data: 1 request value, 0 word just read
      logic idx_dec;
      logic idx_inc;
      logic cnt_inc;
      logic cnt_dec;
      logic cnt_clr;
      logic set_full;
      logic set_bad;
      logic take_rdata;
      logic rsp_load;    // move result into output register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   pos_ok;
      logic   idx_zero;
      logic   idx_last;
      logic   ge;        // word just read >= request value
   } dp_flags_type;

endpackage

// File: src/sle_req_if.sv
// request channel: valid/ready with opcode, value and position
interface sle_req_if import sle_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         opcode;
   logic signed [VAL_W-1:0] value;
   logic [POS_W-1:0]        position;

   modport source (output valid, output opcode, output value, output position, input ready);
   modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

// File: src/sle_rsp_if.sv
// response channel: valid/ready with status, read data and list length
interface sle_rsp_if import sle_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ST_W-1:0]         status;
   logic signed [VAL_W-1:0] read_value;
   logic [LEN_W-1:0]        length;
   logic                    is_empty;

   modport source (output valid, output status, output read_value, output length,
                   output is_empty, input ready);
   modport sink   (input valid, input status, input read_value, input length,
                   input is_empty, output ready);
endinterface

// File: src/sle_dpath.sv
// datapath: list memory, entry count, walk index and result registers
module sle_dpath import sle_pkg::*; #(
   parameter int CAPACITY = SLE_CAPACITY
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [OP_W-1:0]         req_opcode,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic [POS_W-1:0]        req_position,
   input  ctrl_cmd_type            cmd,
   output dp_flags_type            flags,
   output logic [ST_W-1:0]         rsp_status,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic [LEN_W-1:0]        rsp_length,
   output logic                    rsp_is_empty
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

   logic [VAL_W-1:0] mem [CAPACITY];

   op_type                  op_ff, op_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           count_ff, count_in;
   status_type              status_ff, status_in;
   logic signed [VAL_W-1:0] rdata_ff, rdata_in;
   logic signed [VAL_W-1:0] mem_rd_ff;
   logic [ST_W-1:0]         rsp_status_ff, rsp_status_in;
   logic signed [VAL_W-1:0] rsp_rdata_ff, rsp_rdata_in;
   logic [LEN_W-1:0]        rsp_len_ff, rsp_len_in;
   logic                    rsp_empty_ff, rsp_empty_in;

   logic [AW-1:0]           idx_plus, idx_minus, pos_addr, rd_addr;
   logic signed [VAL_W-1:0] wr_data;

   always_comb begin
      idx_plus  = idx_ff + AW'(1);
      idx_minus = idx_ff - AW'(1);
      pos_addr  = AW'(pos_ff - POS_W'(1));
      case (op_ff)
         OP_INSERT: rd_addr = idx_minus;
         OP_REMOVE: rd_addr = idx_plus;
         default:   rd_addr = pos_addr;
      endcase
      wr_data = cmd.wr_value ? val_ff : mem_rd_ff;
   end

   always_comb begin
      op_in  = op_ff;
      val_in = val_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      if (cmd.capture) begin
         op_in  = op_type'(req_opcode);
         val_in = req_value;
         pos_in = req_position;
         // insert walks the hole down from the tail, remove walks it up
         if (op_type'(req_opcode) == OP_INSERT) begin
            idx_in = AW'(count_ff);
         end else begin
            idx_in = AW'(req_position - POS_W'(1));
         end
      end else if (cmd.idx_dec) begin
         idx_in = idx_minus;
      end else if (cmd.idx_inc) begin
         idx_in = idx_plus;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      status_in = status_ff;
      rdata_in  = rdata_ff;
      if (cmd.capture) begin
         status_in = STATUS_DONE;
         rdata_in  = '0;
      end else begin
         if (cmd.set_full) begin
            status_in = STATUS_FULL;
         end else if (cmd.set_bad) begin
            status_in = STATUS_BAD_POS;
         end
         if (cmd.take_rdata) begin
            rdata_in = mem_rd_ff;
         end
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (cmd.rsp_load) begin
         rsp_status_in = status_ff;
         rsp_rdata_in  = rdata_ff;
         rsp_len_in    = LEN_W'(count_ff);
         rsp_empty_in  = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rdata_ff      <= rdata_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // list storage, one port read or written per cycle
   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[idx_ff] <= wr_data;
      end
      if (cmd.mem_read) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      flags.op       = op_ff;
      flags.full     = (count_ff == CW'(CAPACITY));
      flags.pos_ok   = (pos_ff != '0) && (CMP_W'(pos_ff) <= CMP_W'(count_ff));
      flags.idx_zero = (idx_ff == '0);
      flags.idx_last = ((CW'(idx_ff) + CW'(1)) == count_ff);
      flags.ge       = (mem_rd_ff >= val_ff);
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_rdata_ff;
   assign rsp_length     = rsp_len_ff;
   assign rsp_is_empty   = rsp_empty_ff;

endmodule

// File: src/sle_ctrl.sv
// controller: request handshake, list walk sequencing, response valid
module sle_ctrl import sle_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dp_flags_type flags,
   output ctrl_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_LOOK  = 4'b0010,
      S_CHECK = 4'b0100,
      S_REPLY = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            case (flags.op)
               OP_INSERT: begin
                  if (flags.full) begin
                     cmd.set_full = 1'b1;
                     state_in     = S_REPLY;
                  end else if (flags.idx_zero) begin
                     cmd.mem_write = 1'b1;
                     cmd.wr_value  = 1'b1;
                     cmd.cnt_inc   = 1'b1;
                     state_in      = S_REPLY;
                  end else begin
                     cmd.mem_read = 1'b1;
                     state_in     = S_CHECK;
                  end
               end
               OP_REMOVE: begin
                  if (!flags.pos_ok) begin
                     cmd.set_bad = 1'b1;
                     state_in    = S_REPLY;
                  end else if (flags.idx_last) begin
                     cmd.cnt_dec = 1'b1;
                     state_in    = S_REPLY;
                  end else begin
                     cmd.mem_read = 1'b1;
                     state_in     = S_CHECK;
                  end
               end
               OP_READ: begin
                  if (!flags.pos_ok) begin
                     cmd.set_bad = 1'b1;
                     state_in    = S_REPLY;
                  end else begin
                     cmd.mem_read = 1'b1;
                     state_in     = S_CHECK;
                  end
               end
               default: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_REPLY;
               end
            endcase
         end
         S_CHECK: begin
            case (flags.op)
               OP_INSERT: begin
                  cmd.mem_write = 1'b1;
                  if (flags.ge) begin
                     // move the larger word up, keep walking down
                     cmd.idx_dec = 1'b1;
                     state_in    = S_LOOK;
                  end else begin
                     cmd.wr_value = 1'b1;
                     cmd.cnt_inc  = 1'b1;
                     state_in     = S_REPLY;
                  end
               end
               OP_REMOVE: begin
                  cmd.mem_write = 1'b1;
                  cmd.idx_inc   = 1'b1;
                  state_in      = S_LOOK;
               end
               default: begin
                  cmd.take_rdata = 1'b1;
                  state_in       = S_REPLY;
               end
            endcase
         end
         S_REPLY: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/sorted_list_engine_core.sv
// top level of the sorted list engine: controller plus datapath
//
// keeps up to CAPACITY signed 32-bit words in ascending order
// req_if carries opcode (insert, remove, read, clear), value and a 1-based
// position; a transfer happens on valid and ready both high
// rsp_if returns one transfer per request: status, read data (zero unless
// a good read), list length after the request and an empty flag
// one request is worked at a time; the single-port list memory is walked
// one word at a time (read, then write); the steps are:
//   full insert, bad position, clear, insert into empty list: straight to
//   the response; read: one word read; insert: a read and a write per word
//   moved up, then one more read (unless the new word lands at the head)
//   and the new word written; remove: a read and a write per word moved down
// the next request can be taken in the cycle after the response is loaded
// a response waiting in the output register does not block the next
// request; only loading a new response waits for the old one to go
// reset (synchronous) empties the list and drops any pending response;
// list words themselves are not cleared, only the count is
module sorted_list_engine_core import sle_pkg::*; #(
   parameter int CAPACITY = SLE_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   sle_req_if.sink    req_if,
   sle_rsp_if.source  rsp_if
);

   ctrl_cmd_type cmd;
   dp_flags_type flags;

   // sequencing: idle, address/decide, data back/write, response load
   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   // storage, count and result registers
   sle_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_opcode     (req_if.opcode),
      .req_value      (req_if.value),
      .req_position   (req_if.position),
      .cmd            (cmd),
      .flags          (flags),
      .rsp_status     (rsp_if.status),
      .rsp_read_value (rsp_if.read_value),
      .rsp_length     (rsp_if.length),
      .rsp_is_empty   (rsp_if.is_empty)
   );

endmodule
